### sv/wcg_pkg.sv
// ----------------------------------------------------------------------------
// Window coefficient generator package
// Shared widths, fixed-point constants, data types and arithmetic helpers.
// ----------------------------------------------------------------------------
package wcg_pkg;

    localparam int IDX_W      = 12;
    localparam int LEN_W      = 13;
    localparam int COEF_W     = 16;
    localparam int FRAC_BITS  = 15;
    localparam int MIN_LENGTH = 2;
    localparam int MAX_LENGTH = 4096;
    localparam int Q          = 30;

    localparam int NUM_W = 42;
    localparam int QUO_W = 31;
    localparam int DVS_W = 12;
    localparam int REM_W = 12;

    localparam int HORNER_STEPS = 6;
    localparam int HORNER_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};

    localparam logic signed [31:0] ONE_Q  = 32'sd1073741824;
    localparam logic [31:0]        PI_Q30 = 32'd3373259426;
    localparam logic signed [31:0] C_054  = 32'sd579820585;
    localparam logic signed [31:0] C_046  = 32'sd493921239;
    localparam logic signed [31:0] C_042  = 32'sd450971566;
    localparam logic signed [31:0] C_008  = 32'sd85899346;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);

    localparam logic [2:0] WIN_RECT     = 3'd0;
    localparam logic [2:0] WIN_BARTLETT = 3'd1;
    localparam logic [2:0] WIN_HANN     = 3'd2;
    localparam logic [2:0] WIN_HAMMING  = 3'd3;
    localparam logic [2:0] WIN_BLACKMAN = 3'd4;

    typedef struct packed {
        logic              oor;
        logic              zero_out;
        logic [2:0]        wtype;
        logic              neg;
        logic [COEF_W-1:0] bart_coef;
    } ctx_t;

    typedef struct packed {
        ctx_t             ctx;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] bits;
        logic [QUO_W-1:0] quo;
        logic [DVS_W-1:0] dvs;
    } div_t;

    typedef struct packed {
        ctx_t               ctx;
        logic signed [32:0] t;
        logic [31:0]        y;
    } hrn_t;

    // Q30 product with rounding half away from zero.
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic        neg;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] p;
        neg = a[31] ^ b[31];
        ua  = a[31] ? 32'(-a) : 32'(a);
        ub  = b[31] ? 32'(-b) : 32'(b);
        p   = ({32'b0, ua} * {32'b0, ub} + 64'd536870912) >> Q;
        return neg ? -$signed(p[31:0]) : $signed(p[31:0]);
    endfunction

    // Clamp a Q30 value to 0..1 and round half up to the output format.
    function automatic logic [COEF_W-1:0] to_out(input logic signed [33:0] w);
        logic [30:0] u;
        logic [31:0] s;
        if (w < 0)
            u = 31'd0;
        else if (w > 34'sd1073741824)
            u = 31'd1073741824;
        else
            u = w[30:0];
        s = {1'b0, u} + 32'(1 << (Q - FRAC_BITS - 1));
        return COEF_W'(s >> (Q - FRAC_BITS));
    endfunction

endpackage

### sv/wcg_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: develops one quotient bit and passes the
// partial remainder, remaining dividend bits and item context to the next cell.
// ----------------------------------------------------------------------------
module wcg_div_cell
    import wcg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [REM_W:0]   trial;
    logic             ge;

    always_comb
    begin
        trial     = {in_data.rem, in_data.bits[QUO_W-1]};
        ge        = trial >= {1'b0, in_data.dvs};
        data_next = in_data;
        data_next.rem  = ge ? REM_W'(trial - {1'b0, in_data.dvs}) : trial[REM_W-1:0];
        data_next.bits = {in_data.bits[QUO_W-2:0], 1'b0};
        data_next.quo  = {in_data.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.rem < out_data.dvs))
        else $error("partial remainder not below divisor");

endmodule

### sv/wcg_horner_cell.sv
// ----------------------------------------------------------------------------
// Horner cell
// One step of the cosine polynomial, t' = 1 - round(t*y)/Q_DIV, over three
// register stages: product, reciprocal quotient estimate, correction.
// ----------------------------------------------------------------------------
module wcg_horner_cell
    import wcg_pkg::*;
#(
    parameter int Q_DIV = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  hrn_t in_data,
    output logic out_valid,
    output hrn_t out_data
);

    localparam logic [33:0] RECIP = 34'((64'd1 << 34) / Q_DIV);

    logic        a_valid_reg, b_valid_reg, c_valid_reg;
    ctx_t        a_ctx_reg, b_ctx_reg;
    logic [31:0] a_y_reg, b_y_reg;
    logic [32:0] a_p_reg, b_p_reg, b_q0_reg;
    hrn_t        c_data_reg;

    logic [62:0] prod_a;
    logic [32:0] p_next;
    logic [66:0] prod_b;
    logic [32:0] q0_next;
    logic [32:0] qq;
    logic [32:0] rem_c;
    logic [32:0] quo_c;
    hrn_t        c_next;

    always_comb
    begin
        prod_a  = {32'b0, in_data.t[30:0]} * {31'b0, in_data.y};
        p_next  = 33'((prod_a + 63'd536870912) >> Q);
        prod_b  = {34'b0, a_p_reg} * {33'b0, RECIP};
        q0_next = 33'(prod_b >> 34);
        qq      = 33'(b_q0_reg * 33'(Q_DIV));
        rem_c   = b_p_reg - qq;
        quo_c   = b_q0_reg + {32'b0, (rem_c >= 33'(Q_DIV))};
        c_next.ctx = b_ctx_reg;
        c_next.y   = b_y_reg;
        c_next.t   = 33'sd1073741824 - $signed(quo_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctx_reg  <= in_data.ctx;
            a_y_reg    <= in_data.y;
            a_p_reg    <= p_next;
            b_ctx_reg  <= a_ctx_reg;
            b_y_reg    <= a_y_reg;
            b_p_reg    <= a_p_reg;
            b_q0_reg   <= q0_next;
            c_data_reg <= c_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

### sv/window_coefficient_generator.sv
// ----------------------------------------------------------------------------
// Window coefficient generator
// Returns the Q1.15 window coefficient of one sample index for the configured
// window type and length.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the skid entry is empty; set by the 31-cell
// divider chain and the six three-stage Horner cells, all fully pipelined.
// A two-entry output (register plus skid) stalls the whole pipeline only when full.
// Reset clears all valid bits; window type resets to rectangular, length to 1024.
module window_coefficient_generator
    import wcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [IDX_W-1:0]  sample_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [COEF_W-1:0] coefficient,
    output logic              index_out_of_range
);

    typedef enum logic {
        REG_WINDOW_TYPE   = 1'b0,
        REG_WINDOW_LENGTH = 1'b1
    } cfg_reg_t;

    logic [2:0]       window_type_reg;
    logic [LEN_W-1:0] window_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_type_reg   <= WIN_RECT;
            window_length_reg <= LEN_W'(1024);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_TYPE:   window_type_reg   <= cfg_data[2:0];
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // Front end: decode the index into a fold, a divisor and a numerator term.
    logic [LEN_W-1:0] len_c, n_ext, m13, ak, ak_b, diff, d13, j0, j_f;
    logic [DVS_W-1:0] m, d_cos;
    logic             is_bart, fold;
    ctx_t             ctx0;

    always_comb
    begin
        if (window_length_reg < LEN_W'(MIN_LENGTH))
            len_c = LEN_W'(MIN_LENGTH);
        else if (window_length_reg > LEN_W'(MAX_LENGTH))
            len_c = LEN_W'(MAX_LENGTH);
        else
            len_c = window_length_reg;
        n_ext   = LEN_W'(sample_index);
        m       = DVS_W'(len_c >> 1);
        m13     = LEN_W'(m);
        ak      = (n_ext >= m13) ? n_ext - m13 : m13 - n_ext;
        ak_b    = (ak > m13) ? m13 : ak;
        diff    = m13 - ak_b;
        d_cos   = (window_type_reg == WIN_HANN) ? m + DVS_W'(1) : m;
        d13     = LEN_W'(d_cos);
        j0      = (ak > d13) ? d13 : ak;
        fold    = {j0, 1'b0} > {1'b0, d13};
        j_f     = fold ? d13 - j0 : j0;
        is_bart = window_type_reg == WIN_BARTLETT;
        ctx0.oor       = n_ext >= len_c;
        ctx0.zero_out  = n_ext == {m, 1'b0};
        ctx0.wtype     = window_type_reg;
        ctx0.neg       = fold;
        ctx0.bart_coef = '0;
    end

    logic             s0_valid_reg;
    ctx_t             s0_ctx_reg;
    logic [DVS_W-1:0] s0_jn_reg, s0_dvs_reg;
    logic             s0_bart_reg;

    // Numerator: j*pi or the Bartlett distance scaled to the output format.
    logic [43:0]      pm;
    logic [NUM_W-1:0] numer;
    div_t             div0;
    logic             s1_valid_reg;
    div_t             s1_div_reg;

    always_comb
    begin
        pm    = {32'b0, s0_jn_reg} * {12'b0, PI_Q30};
        numer = (s0_bart_reg ? NUM_W'({s0_jn_reg, {FRAC_BITS{1'b0}}}) : pm[NUM_W-1:0])
                + NUM_W'(s0_dvs_reg >> 1);
        div0.ctx  = s0_ctx_reg;
        div0.rem  = REM_W'(numer[NUM_W-1:QUO_W]);
        div0.bits = numer[QUO_W-1:0];
        div0.quo  = '0;
        div0.dvs  = s0_dvs_reg;
    end

    logic div_valid [QUO_W+1];
    div_t div_data  [QUO_W+1];
    assign div_valid[0] = s1_valid_reg;
    assign div_data[0]  = s1_div_reg;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        wcg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // Angle squared, and the Bartlett quotient parked in the context.
    logic [QUO_W-1:0] x;
    logic [61:0]      xx;
    hrn_t             hrn0_next;
    logic             y_valid_reg;
    hrn_t             y_data_reg;

    always_comb
    begin
        x  = div_data[QUO_W].quo;
        xx = {31'b0, x} * {31'b0, x};
        hrn0_next.ctx           = div_data[QUO_W].ctx;
        hrn0_next.ctx.bart_coef = x[COEF_W-1:0];
        hrn0_next.y             = 32'((xx + 62'd536870912) >> Q);
        hrn0_next.t             = 33'sd1073741824;
    end

    logic hrn_valid [HORNER_STEPS+1];
    hrn_t hrn_data  [HORNER_STEPS+1];
    assign hrn_valid[0] = y_valid_reg;
    assign hrn_data[0]  = y_data_reg;

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_hrn
        wcg_horner_cell #(
            .Q_DIV (HORNER_DIV[i])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (hrn_valid[i]),
            .in_data   (hrn_data[i]),
            .out_valid (hrn_valid[i+1]),
            .out_data  (hrn_data[i+1])
        );
    end

    // Cosine clamp and sign, then the window formulas.
    logic signed [32:0] t_last, t_cl;
    logic signed [31:0] c_next;
    logic               cs_valid_reg;
    ctx_t               cs_ctx_reg;
    logic signed [31:0] cs_c_reg;

    always_comb
    begin
        t_last = hrn_data[HORNER_STEPS].t;
        if (t_last < 0)
            t_cl = '0;
        else if (t_last > 33'sd1073741824)
            t_cl = 33'sd1073741824;
        else
            t_cl = t_last;
        c_next = hrn_data[HORNER_STEPS].ctx.neg ? -t_cl[31:0] : t_cl[31:0];
    end

    logic signed [32:0] hsum;
    logic signed [31:0] half_next;
    logic               c1_valid_reg;
    ctx_t               c1_ctx_reg;
    logic signed [31:0] c1_hann_reg, c1_hamp_reg, c1_cc_reg, c1_half_reg;

    always_comb
    begin
        hsum      = 33'sd1073741824 + {cs_c_reg[31], cs_c_reg};
        half_next = (cs_c_reg + $signed({31'b0, cs_c_reg[31]})) >>> 1;
    end

    logic signed [32:0] e33;
    logic signed [31:0] whh_next;
    logic               c2_valid_reg;
    ctx_t               c2_ctx_reg;
    logic signed [31:0] c2_whh_reg, c2_blb_reg, c2_blm_reg;

    always_comb
    begin
        e33      = $signed({c1_cc_reg, 1'b0}) - 33'sd1073741824;
        whh_next = (c1_ctx_reg.wtype == WIN_HANN) ? c1_hann_reg : C_054 + c1_hamp_reg;
    end

    logic signed [33:0] w;
    logic [COEF_W-1:0]  new_coef;

    always_comb
    begin
        if (c2_ctx_reg.wtype == WIN_BLACKMAN)
            w = {{2{c2_blb_reg[31]}}, c2_blb_reg} + {{2{c2_blm_reg[31]}}, c2_blm_reg};
        else
            w = {{2{c2_whh_reg[31]}}, c2_whh_reg};
        if (c2_ctx_reg.oor)
            new_coef = '0;
        else
        begin
            unique case (c2_ctx_reg.wtype)
                WIN_RECT:     new_coef = COEF_ONE;
                WIN_BARTLETT: new_coef = c2_ctx_reg.bart_coef;
                WIN_HANN, WIN_HAMMING, WIN_BLACKMAN:
                    new_coef = c2_ctx_reg.zero_out ? '0 : to_out(w);
                default:      new_coef = COEF_ONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            y_valid_reg  <= 1'b0;
            cs_valid_reg <= 1'b0;
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            y_valid_reg  <= div_valid[QUO_W];
            cs_valid_reg <= hrn_valid[HORNER_STEPS];
            c1_valid_reg <= cs_valid_reg;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ctx_reg  <= ctx0;
            s0_jn_reg   <= is_bart ? diff[DVS_W-1:0] : j_f[DVS_W-1:0];
            s0_dvs_reg  <= is_bart ? m : d_cos;
            s0_bart_reg <= is_bart;
            s1_div_reg  <= div0;
            y_data_reg  <= hrn0_next;
            cs_ctx_reg  <= hrn_data[HORNER_STEPS].ctx;
            cs_c_reg    <= c_next;
            c1_ctx_reg  <= cs_ctx_reg;
            c1_hann_reg <= hsum[32:1];
            c1_hamp_reg <= mulq(C_046, cs_c_reg);
            c1_cc_reg   <= mulq(cs_c_reg, cs_c_reg);
            c1_half_reg <= half_next;
            c2_ctx_reg  <= c1_ctx_reg;
            c2_whh_reg  <= whh_next;
            c2_blb_reg  <= C_042 + c1_half_reg;
            c2_blm_reg  <= mulq(C_008, e33[31:0]);
        end
    end

    // Output register with a skid entry behind it.
    logic              out_valid_reg;
    logic [COEF_W-1:0] out_coef_reg, skid_coef_reg;
    logic              out_flag_reg, skid_flag_reg;
    logic              out_take, load_from_skid, load_new, load_skid;

    always_comb
    begin
        out_take       = out_valid_reg && out_ready;
        load_from_skid = skid_valid_reg && out_take;
        load_new       = !skid_valid_reg && c2_valid_reg && (!out_valid_reg || out_take);
        load_skid      = !skid_valid_reg && c2_valid_reg && out_valid_reg && !out_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_from_skid)
                skid_valid_reg <= 1'b0;
            else if (load_skid)
                skid_valid_reg <= 1'b1;
            if (load_new)
                out_valid_reg <= 1'b1;
            else if (out_take && !skid_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
        begin
            out_coef_reg <= skid_coef_reg;
            out_flag_reg <= skid_flag_reg;
        end
        else if (load_new)
        begin
            out_coef_reg <= new_coef;
            out_flag_reg <= c2_ctx_reg.oor;
        end
        if (load_skid)
        begin
            skid_coef_reg <= new_coef;
            skid_flag_reg <= c2_ctx_reg.oor;
        end
    end

    assign out_valid          = out_valid_reg;
    assign coefficient        = out_coef_reg;
    assign index_out_of_range = out_flag_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && index_out_of_range) |-> (coefficient == '0))
        else $error("out-of-range item with nonzero coefficient");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coefficient <= COEF_ONE))
        else $error("coefficient above one");

endmodule
